FILE: rtl/rws_pkg.sv
// Shared widths and codes for the roulette wheel selector.
package rws_pkg;

    localparam int FIT_W     = 32;            // Q0.32 fitness
    localparam int IN_W      = 32;            // Q16.16 time / energy, Q0.32 fraction
    localparam int DEN_W     = 34;            // 1.0 + time + energy, Q18.16
    localparam int QUO_W     = 33;            // raw quotient, saturated to FIT_W
    localparam int DIV_STEPS = 49;            // one quotient bit per dividend bit of 2^48
    localparam int TOT_W     = 40;            // saturating fitness total
    localparam int HALF_W    = 20;            // total split for the 20 x 32 multiplier
    localparam int PROD_W    = HALF_W + IN_W;
    localparam int ACC_W     = TOT_W + IN_W;
    localparam int IDX_OUT_W = 8;

    localparam logic [DEN_W-1:0] ONE_Q16 = DEN_W'(65536);

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_LOAD   = 2'd1;
    localparam logic [1:0] CMD_SELECT = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

endpackage

FILE: rtl/roulette_wheel_selector_unit.sv
// Roulette wheel selector top level: command sequencer, fitness store and walk.
//
//  channel | signals                                          | dir
//  --------+--------------------------------------------------+-----
//  input   | in_valid in_ready cmd finish_time energy_use     | in
//          | random_fraction                                  |
//  output  | out_valid out_ready chosen_index status          | out
//          | fitness_value                                    |
//
// Clear, unused command and error cases: accept, then the finish state, then the next accept.
// Load: runs the 49-step bit-serial reciprocal divider, then the finish state.
// Select: two-pass 20x32 point multiply (MUL_LO, MUL_HI, ACC) and read priming (PRIME), then one
// store entry per cycle from the memory's single read port, then the finish state.
// Reset clears count, total and handshake state; the store needs no clearing.
// A waiting result holds only the next transaction's completion, not its accept.
module roulette_wheel_selector_unit #(
    parameter int POP_DEPTH = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    cmd,
    input  logic [rws_pkg::IN_W-1:0]      finish_time,
    input  logic [rws_pkg::IN_W-1:0]      energy_use,
    input  logic [rws_pkg::IN_W-1:0]      random_fraction,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [rws_pkg::IDX_OUT_W-1:0] chosen_index,
    output logic [1:0]                    status,
    output logic [rws_pkg::FIT_W-1:0]     fitness_value
);
    import rws_pkg::*;

    localparam int IDX_W = $clog2(POP_DEPTH);
    localparam int CNT_W = $clog2(POP_DEPTH + 1);
    localparam int SUM_W = (FIT_W + CNT_W > TOT_W) ? FIT_W + CNT_W : TOT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_ACC,
        ST_PRIME,
        ST_WALK,
        ST_FINISH
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [TOT_W-1:0]     total_reg, total_next;
    logic [IN_W-1:0]      frac_reg, frac_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic [TOT_W-1:0]     point_reg, point_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [IDX_W-1:0]     cmp_reg, cmp_next;
    logic [IDX_W-1:0]     issue_reg, issue_next;
    logic [IDX_OUT_W-1:0] res_idx_reg, res_idx_next;
    logic [1:0]           res_status_reg, res_status_next;
    logic [FIT_W-1:0]     res_fit_reg, res_fit_next;
    logic                 out_valid_reg, out_valid_next;
    logic [IDX_OUT_W-1:0] out_idx_reg, out_idx_next;
    logic [1:0]           out_status_reg, out_status_next;
    logic [FIT_W-1:0]     out_fit_reg, out_fit_next;

    logic [FIT_W-1:0]     mem [POP_DEPTH];
    logic [FIT_W-1:0]     rd_data_reg;
    logic                 mem_we;

    logic                 div_start;
    logic                 div_done;
    logic [FIT_W-1:0]     div_q;
    logic [DEN_W-1:0]     den;

    logic [HALF_W-1:0]    mul_a;
    logic [PROD_W-1:0]    mul_p;
    logic [ACC_W-1:0]     acc_sum;
    logic [TOT_W:0]       tot_sum;
    logic [SUM_W-1:0]     sum_cmp;
    logic                 walk_stop;
    logic [31:0]          count_wide;
    logic [31:0]          cmp_wide;
    logic                 in_take;

    assign in_take  = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign den      = ONE_Q16 + DEN_W'(finish_time) + DEN_W'(energy_use);

    assign div_start = in_take && (cmd == CMD_LOAD) && (count_reg != CNT_W'(POP_DEPTH));

    rws_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .den   (den),
        .done  (div_done),
        .quot  (div_q)
    );

    // one 20x32 multiplier, low half of the total first
    assign mul_a   = (state_reg == ST_MUL_HI) ? total_reg[TOT_W-1:HALF_W]
                                              : total_reg[HALF_W-1:0];
    assign mul_p   = PROD_W'(mul_a) * PROD_W'(frac_reg);
    assign acc_sum = acc_reg + (ACC_W'(prod_reg) << HALF_W);
    assign tot_sum = {1'b0, total_reg} + (TOT_W + 1)'(div_q);

    assign sum_cmp    = sum_reg + SUM_W'(rd_data_reg);
    // the last entry is the fallback, and its data is already in rd_data_reg
    assign walk_stop  = (sum_cmp >= SUM_W'(point_reg))
                        || ((CNT_W'(cmp_reg) + CNT_W'(1)) == count_reg);
    assign count_wide = 32'(count_reg);
    assign cmp_wide   = 32'(cmp_reg);
    assign mem_we     = (state_reg == ST_DIV) && div_done;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[count_reg[IDX_W-1:0]] <= div_q;
        end
        rd_data_reg <= mem[issue_reg];
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        total_next      = total_reg;
        frac_next       = frac_reg;
        prod_next       = prod_reg;
        acc_next        = acc_reg;
        point_next      = point_reg;
        sum_next        = sum_reg;
        cmp_next        = cmp_reg;
        issue_next      = issue_reg;
        res_idx_next    = res_idx_reg;
        res_status_next = res_status_reg;
        res_fit_next    = res_fit_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_idx_next    = out_idx_reg;
        out_status_next = out_status_reg;
        out_fit_next    = out_fit_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    res_idx_next    = '0;
                    res_status_next = STATUS_OK;
                    res_fit_next    = '0;
                    frac_next       = random_fraction;
                    state_next      = ST_FINISH;
                    unique case (cmd)
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                            total_next = '0;
                        end
                        CMD_LOAD:
                        begin
                            if (count_reg == CNT_W'(POP_DEPTH))
                            begin
                                res_status_next = STATUS_FULL;
                            end
                            else
                            begin
                                state_next = ST_DIV;
                            end
                        end
                        CMD_SELECT:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                state_next = ST_MUL_LO;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    count_next   = count_reg + CNT_W'(1);
                    total_next   = tot_sum[TOT_W] ? '1 : tot_sum[TOT_W-1:0];
                    res_idx_next = count_wide[IDX_OUT_W-1:0];
                    res_fit_next = div_q;
                    state_next   = ST_FINISH;
                end
            end
            ST_MUL_LO:
            begin
                prod_next  = mul_p;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI:
            begin
                acc_next   = ACC_W'(prod_reg);
                prod_next  = mul_p;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                point_next = acc_sum[ACC_W-1:IN_W];
                sum_next   = '0;
                cmp_next   = '0;
                issue_next = '0;
                state_next = ST_PRIME;
            end
            ST_PRIME:
            begin
                issue_next = issue_reg + IDX_W'(1);
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (issue_reg != IDX_W'(POP_DEPTH - 1))
                begin
                    issue_next = issue_reg + IDX_W'(1);
                end
                if (walk_stop)
                begin
                    res_idx_next = cmp_wide[IDX_OUT_W-1:0];
                    res_fit_next = rd_data_reg;
                    state_next   = ST_FINISH;
                end
                else
                begin
                    sum_next = sum_cmp;
                    cmp_next = cmp_reg + IDX_W'(1);
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_idx_next    = res_idx_reg;
                    out_status_next = res_status_reg;
                    out_fit_next    = res_fit_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            total_reg      <= '0;
            out_valid_reg  <= 1'b0;
            frac_reg       <= '0;
            prod_reg       <= '0;
            acc_reg        <= '0;
            point_reg      <= '0;
            sum_reg        <= '0;
            cmp_reg        <= '0;
            issue_reg      <= '0;
            res_idx_reg    <= '0;
            res_status_reg <= STATUS_OK;
            res_fit_reg    <= '0;
            out_idx_reg    <= '0;
            out_status_reg <= STATUS_OK;
            out_fit_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            total_reg      <= total_next;
            out_valid_reg  <= out_valid_next;
            frac_reg       <= frac_next;
            prod_reg       <= prod_next;
            acc_reg        <= acc_next;
            point_reg      <= point_next;
            sum_reg        <= sum_next;
            cmp_reg        <= cmp_next;
            issue_reg      <= issue_next;
            res_idx_reg    <= res_idx_next;
            res_status_reg <= res_status_next;
            res_fit_reg    <= res_fit_next;
            out_idx_reg    <= out_idx_next;
            out_status_reg <= out_status_next;
            out_fit_reg    <= out_fit_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign chosen_index  = out_idx_reg;
    assign status        = out_status_reg;
    assign fitness_value = out_fit_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(POP_DEPTH))
        else $error("member count above store depth");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside a load");

    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WALK |-> (CNT_W'(cmp_reg) < count_reg))
        else $error("walk index past member count");

    a_error_zero_fit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg != STATUS_OK
            |-> out_fit_reg == '0 && out_idx_reg == '0)
        else $error("error transaction carries nonzero payload");

endmodule

FILE: rtl/rws_div.sv
// Restoring bit-serial divider: saturated floor(2^48 / den), one bit per cycle.
module rws_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [rws_pkg::DEN_W-1:0] den,
    output logic                      done,
    output logic [rws_pkg::FIT_W-1:0] quot
);
    import rws_pkg::*;

    localparam int STEP_W = $clog2(DIV_STEPS);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;

    logic [DEN_W:0]    shifted;
    logic              ge;

    always_comb
    begin
        // the dividend 2^48 has a single one, shifted in on the first step
        shifted   = {rem_reg, (step_reg == '0)};
        ge        = shifted >= {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            den_next  = den;
            rem_next  = '0;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? DEN_W'(shifted - {1'b0, den_reg}) : shifted[DEN_W-1:0];
            quo_next = {quo_reg[QUO_W-2:0], ge};
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            den_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
            den_reg  <= den_next;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
        end
    end

    assign done = done_reg;
    // only a denominator of exactly 1.0 reaches 2^32
    assign quot = quo_reg[QUO_W-1] ? '1 : quo_reg[FIT_W-1:0];

endmodule

FILE: tb/sv/tb.sv
// Testbench for roulette_wheel_selector_unit: queued stimulus, in-bench wheel prediction.
`timescale 1ns / 100ps

module tb;
    import rws_pkg::*;

    localparam int POP_DEPTH = 256;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int HOLD_CYCLES = 2500;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [TOT_W-1:0] TOTAL_MAX = '1;

    typedef struct packed {
        logic [1:0]      cmd;
        logic [IN_W-1:0] ctime;
        logic [IN_W-1:0] energy;
        logic [IN_W-1:0] frac;
    } wheel_cmd_t;

    typedef struct packed {
        logic [IDX_OUT_W-1:0] idx;
        logic [1:0]           status;
        logic [FIT_W-1:0]     fit;
    } wheel_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [1:0]           cmd = CMD_CLEAR;
    logic [IN_W-1:0]      finish_time = '0;
    logic [IN_W-1:0]      energy_use = '0;
    logic [IN_W-1:0]      random_fraction = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [IDX_OUT_W-1:0] chosen_index;
    logic [1:0]           status;
    logic [FIT_W-1:0]     fitness_value;

    // predicted population
    logic [FIT_W-1:0] roster_fit [POP_DEPTH];
    int               roster_count = 0;
    logic [TOT_W-1:0] roster_total = '0;

    wheel_cmd_t    cmd_backlog [$];
    wheel_result_t due_results [$];
    wheel_cmd_t    next_cmd;
    wheel_result_t got;
    wheel_result_t want;

    int  err_count = 0;
    int  cycle_count = 0;
    int  accepted_count = 0;
    int  n_items = 0;
    bit  hold_out = 1'b0;
    wire calm = (accepted_count >= 600) && (accepted_count < 900);

    roulette_wheel_selector_unit #(
        .POP_DEPTH(POP_DEPTH)
    ) DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .cmd             (cmd),
        .finish_time     (finish_time),
        .energy_use      (energy_use),
        .random_fraction (random_fraction),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .chosen_index    (chosen_index),
        .status          (status),
        .fitness_value   (fitness_value)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic flag_mismatch(string what, logic [31:0] exp_v, logic [31:0] got_v);
        $display("mismatch at cycle %0d: %s expected %h got %h", cycle_count, what,
                 exp_v, got_v);
        err_count++;
    endtask

    // Advances the predicted population by one transaction and returns its result.
    function automatic wheel_result_t wheel_step(wheel_cmd_t c);
        wheel_result_t   r;
        logic [DEN_W-1:0] den;
        logic [63:0]     quo;
        logic [71:0]     prod;
        logic [TOT_W-1:0] point;
        logic [47:0]     run_sum;
        logic [TOT_W:0]  new_total;
        int              pick;
        bit              found;
        r = '0;
        case (c.cmd)
            CMD_CLEAR:
            begin
                roster_count = 0;
                roster_total = '0;
            end
            CMD_LOAD:
            begin
                if (roster_count >= POP_DEPTH)
                begin
                    r.status = STATUS_FULL;
                end
                else
                begin
                    den = ONE_Q16 + DEN_W'(c.ctime) + DEN_W'(c.energy);
                    quo = (64'd1 << 48) / 64'(den);
                    if (quo > 64'hFFFF_FFFF)
                        quo = 64'hFFFF_FFFF;
                    roster_fit[roster_count] = quo[FIT_W-1:0];
                    r.idx = roster_count[IDX_OUT_W-1:0];
                    r.fit = quo[FIT_W-1:0];
                    new_total = (TOT_W+1)'(roster_total) + (TOT_W+1)'(quo[FIT_W-1:0]);
                    roster_total = (new_total > (TOT_W+1)'(TOTAL_MAX)) ? TOTAL_MAX
                                                                       : new_total[TOT_W-1:0];
                    roster_count++;
                end
            end
            CMD_SELECT:
            begin
                if (roster_count == 0)
                begin
                    r.status = STATUS_EMPTY;
                end
                else
                begin
                    prod = 72'(c.frac) * 72'(roster_total);
                    point = prod[71:32];
                    pick = roster_count - 1;
                    found = 1'b0;
                    run_sum = '0;
                    for (int i = 0; i < roster_count; i++)
                    begin
                        if (!found)
                        begin
                            run_sum = run_sum + 48'(roster_fit[i]);
                            if (run_sum >= 48'(point))
                            begin
                                pick = i;
                                found = 1'b1;
                            end
                        end
                    end
                    r.idx = pick[IDX_OUT_W-1:0];
                    r.fit = roster_fit[pick];
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // Driver: presents queued transactions, predicts each one as it is accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                due_results.push_back(wheel_step({cmd, finish_time, energy_use,
                                                  random_fraction}));
                accepted_count <= accepted_count + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (cmd_backlog.size() != 0 && (calm || $urandom_range(99) >= 23))
                begin
                    next_cmd = cmd_backlog.pop_front();
                    in_valid        <= 1'b1;
                    cmd             <= next_cmd.cmd;
                    finish_time     <= next_cmd.ctime;
                    energy_use      <= next_cmd.energy;
                    random_fraction <= next_cmd.frac;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks every accepted result against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = {chosen_index, status, fitness_value};
                if (due_results.size() == 0)
                begin
                    flag_mismatch("unexpected result, index/fitness", 32'(got.idx), got.fit);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (got.idx != want.idx)
                        flag_mismatch("chosen_index", 32'(want.idx), 32'(got.idx));
                    if (got.status != want.status)
                        flag_mismatch("status", 32'(want.status), 32'(got.status));
                    if (got.fit != want.fit)
                        flag_mismatch("fitness_value", want.fit, got.fit);
                end
            end
            out_ready <= !hold_out && (calm || $urandom_range(99) >= 23);
        end
    end

    // Long receiver stall so the input side backs up.
    initial
    begin
        while (accepted_count < 300)
            @(negedge clk);
        hold_out = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_out = 1'b0;
    end

    function automatic logic [IN_W-1:0] rand_q16();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            2: return $urandom();
            3: return $urandom_range(255);
            4: return $urandom_range(32'h0003_FFFF);
            default: return $urandom() & 32'h00FF_FFFF;
        endcase
    endfunction

    function automatic logic [IN_W-1:0] rand_frac();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            2, 3: return $urandom();
            4: return $urandom_range(1000);
            default: return 32'hFFFF_FFFF - $urandom_range(1000);
        endcase
    endfunction

    task automatic push_cmd(logic [1:0] c, logic [IN_W-1:0] t, logic [IN_W-1:0] e,
                            logic [IN_W-1:0] f);
        cmd_backlog.push_back('{cmd: c, ctime: t, energy: e, frac: f});
        n_items++;
    endtask

    initial
    begin
        int seq_no;
        int roll;
        int n_load;
        int n_sel;

        // directed: empty store, unused code, saturated and tiny fitness, fraction extremes
        push_cmd(CMD_CLEAR, '1, '1, '1);
        push_cmd(CMD_SELECT, '0, '0, 32'h8000_0000);
        push_cmd(CMD_UNUSED, '1, '1, '1);
        push_cmd(CMD_LOAD, '0, '0, '0);
        push_cmd(CMD_LOAD, '1, '1, '0);
        push_cmd(CMD_LOAD, 32'd1, '0, '1);
        push_cmd(CMD_LOAD, 32'h0001_0000, '0, '0);
        push_cmd(CMD_LOAD, '0, 32'h0003_0000, '0);
        push_cmd(CMD_SELECT, '1, '1, '0);
        push_cmd(CMD_SELECT, '0, '0, '1);
        push_cmd(CMD_SELECT, '0, '0, 32'h8000_0000);
        push_cmd(CMD_SELECT, '0, '0, 32'h4000_0000);
        push_cmd(CMD_UNUSED, '0, '0, '0);
        push_cmd(CMD_SELECT, '0, '0, 32'hC000_0000);
        push_cmd(CMD_CLEAR, '0, '0, '0);
        push_cmd(CMD_SELECT, '0, '0, '1);
        push_cmd(CMD_LOAD, 32'h0000_8000, 32'h0000_8000, '0);
        push_cmd(CMD_SELECT, '0, '0, 32'h1234_5678);
        push_cmd(CMD_CLEAR, '0, '0, '0);

        seq_no = 0;
        while (n_items < 1620)
        begin
            seq_no++;
            roll = $urandom_range(99);
            if (roll < 8 && seq_no != 4 && seq_no != 40)
            begin
                case ($urandom_range(3))
                    0: push_cmd(CMD_UNUSED, rand_q16(), rand_q16(), rand_frac());
                    1:
                    begin
                        push_cmd(CMD_CLEAR, rand_q16(), rand_q16(), rand_frac());
                        push_cmd(CMD_SELECT, rand_q16(), rand_q16(), rand_frac());
                    end
                    2: push_cmd(2'($urandom_range(3)), rand_q16(), rand_q16(), rand_frac());
                    default: push_cmd(CMD_SELECT, rand_q16(), rand_q16(), rand_frac());
                endcase
            end
            else
            begin
                push_cmd(CMD_CLEAR, rand_q16(), rand_q16(), rand_frac());
                // two sequences run past a full store
                if (seq_no == 4 || seq_no == 40)
                    n_load = POP_DEPTH + $urandom_range(1, 3);
                else if (roll < 20)
                    n_load = $urandom_range(25, 80);
                else
                    n_load = $urandom_range(1, 16);
                for (int i = 0; i < n_load; i++)
                    push_cmd(CMD_LOAD, rand_q16(), rand_q16(), rand_frac());
                n_sel = $urandom_range(1, 12);
                for (int i = 0; i < n_sel; i++)
                begin
                    if ($urandom_range(9) == 0)
                        push_cmd(CMD_LOAD, rand_q16(), rand_q16(), rand_frac());
                    else
                        push_cmd(CMD_SELECT, rand_q16(), rand_q16(), rand_frac());
                end
            end
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (cmd_backlog.size() != 0 || in_valid || due_results.size() != 0)
            @(negedge clk);
        // wait out a full-store select, which can walk every stored entry
        repeat (POP_DEPTH + 60) @(negedge clk);

        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
